// File: hw/rtl/sine_cosine_poly_unit_core_defines.svh
// Assertion macros shared by the sine/cosine polynomial unit.
// Depends on nothing; the including module must provide aclk and aresetn.
`ifndef SINE_COSINE_POLY_UNIT_CORE_DEFINES_SVH
`define SINE_COSINE_POLY_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/scp_pkg.sv
// Package for the sine/cosine polynomial unit: widths, Q2.30 constants and
// the rounded Q2.30 product. Depends on nothing.
`default_nettype none

package scp_pkg;

    // Default number of bits in the binary angle index.
    localparam int unsigned ANGLE_INDEX_BITS = 20;

    // round(2^32 / (2*pi)) and round(2*pi * 2^32).
    localparam logic [29:0] KIDX = 30'd683565276;
    localparam logic [34:0] KRAD = 35'd26986075409;

    // Width of the folded angle in Q2.30 and its largest value (pi/2).
    localparam int unsigned XW = 31;
    localparam logic [XW-1:0] X_MAX = 31'd1686629713;

    // Signed working type for the polynomial datapath.
    typedef logic signed [32:0] scp_q_t;

    localparam scp_q_t Q30_ONE = 33'sd1073741824;
    localparam scp_q_t SIN_C2  = -33'sd178956971;
    localparam scp_q_t SIN_C4  = 33'sd8947849;
    localparam scp_q_t SIN_C6  = -33'sd205904;
    localparam scp_q_t COS_C2  = -33'sd536870912;
    localparam scp_q_t COS_C4  = 33'sd44739243;
    localparam scp_q_t COS_C6  = -33'sd1427368;

    // Folded angle and the output signs, passed from the index stages to the
    // polynomial stages.
    typedef struct packed {
        logic [XW-1:0] x;
        logic          sin_neg;
        logic          cos_neg;
    } scp_angle_t;

    // Q2.30 product, rounded to nearest with ties away from zero.
    function automatic scp_q_t qmul(input scp_q_t a, input scp_q_t b);
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] p;
        logic [32:0] r;
        ma = a[32] ? 33'(-a) : 33'(a);
        mb = b[32] ? 33'(-b) : 33'(b);
        p  = 66'(ma) * 66'(mb) + (66'(1) << 29);
        r  = p[62:30];
        return (a[32] ^ b[32]) ? -scp_q_t'(r) : scp_q_t'(r);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scp_angle_index.sv
// Three-stage front end: magnitude, binary angle index, quarter-wave fold
// and conversion back to Q2.30 radians. Depends on scp_pkg.
`default_nettype none

module scp_angle_index #(
    parameter int unsigned B = scp_pkg::ANGLE_INDEX_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [31:0]       in_angle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output scp_pkg::scp_angle_t    out_data
);
    import scp_pkg::*;

    localparam int unsigned PW = B + 35;
    localparam logic [B-2:0] QUARTER = (B-1)'(1) << (B - 2);
    localparam logic [PW-1:0] ROUND = PW'(1) << (B + 1);

    logic [2:0]      valid_reg;
    logic [2:0]      en;
    logic [31:0]     mag_reg, mag_next;
    logic            neg_reg;
    logic [B-1:0]    idx_reg, idx_next;
    logic [61:0]     prod;
    logic [B-1:0]    m_low;
    logic [B-2:0]    f_raw, f_fold;
    logic [PW-1:0]   rad_sum;
    scp_angle_t      ang_reg, ang_next;

    // Stage enables: a stage loads when it is empty or its successor loads.
    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // Datapath for the three stages.
    always_comb begin
        mag_next = in_angle[31] ? (32'd0 - in_angle) : in_angle;
        prod     = 62'(mag_reg) * 62'(KIDX);
        m_low    = prod[55:56-B];
        idx_next = neg_reg ? (B'(0) - m_low) : m_low;
        f_raw    = {1'b0, idx_reg[B-3:0]};
        f_fold   = idx_reg[B-2] ? (QUARTER - f_raw) : f_raw;
        rad_sum  = PW'(f_fold) * PW'(KRAD) + ROUND;
        ang_next.x       = rad_sum[B+2+XW-1:B+2];
        ang_next.sin_neg = idx_reg[B-1];
        ang_next.cos_neg = idx_reg[B-1] ^ idx_reg[B-2];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mag_reg <= mag_next;
            neg_reg <= in_angle[31];
        end
        if (en[1]) idx_reg <= idx_next;
        if (en[2]) ang_reg <= ang_next;
    end

    assign out_valid = valid_reg[2];
    assign out_data  = ang_reg;

endmodule

`default_nettype wire

// File: hw/rtl/scp_poly.sv
// Five-stage back end: x squared, Horner steps of both polynomials, final
// sine product and sign application. Depends on scp_pkg.
`default_nettype none

module scp_poly (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire scp_pkg::scp_angle_t   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         sin_value,
    output logic signed [31:0]         cos_value
);
    import scp_pkg::*;

    logic [4:0] valid_reg;
    logic [4:0] en;

    // Per-stage payload. Stage n holds what later stages still need.
    scp_q_t     x0_reg, x1_reg, x2s_reg, x3_reg;
    scp_q_t     sq0_reg, sq1_reg, sq2_reg;
    scp_q_t     sq0_next;
    scp_q_t     ts1_reg, tc1_reg, ts1_next, tc1_next;
    scp_q_t     ts2_reg, tc2_reg, ts2_next, tc2_next;
    scp_q_t     ts3_reg, c3_reg, ts3_next, c3_next;
    scp_q_t     s4;
    logic [1:0] sgn0_reg, sgn1_reg, sgn2_reg, sgn3_reg;
    logic signed [31:0] sin_reg, cos_reg, sin_next, cos_next;
    scp_q_t     x_in;

    // Stage enables: a stage loads when it is empty or its successor loads.
    assign en[4]    = !valid_reg[4] || out_ready;
    assign en[3]    = !valid_reg[3] || en[4];
    assign en[2]    = !valid_reg[2] || en[3];
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
            if (en[3]) valid_reg[3] <= valid_reg[2];
            if (en[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    // Rounded products: x squared, then one per polynomial in each Horner step, then the final sine product.
    always_comb begin
        x_in     = scp_q_t'({2'b00, in_data.x});
        sq0_next = qmul(x_in, x_in);
        ts1_next = SIN_C4 + qmul(sq0_reg, SIN_C6);
        tc1_next = COS_C4 + qmul(sq0_reg, COS_C6);
        ts2_next = SIN_C2 + qmul(sq1_reg, ts1_reg);
        tc2_next = COS_C2 + qmul(sq1_reg, tc1_reg);
        ts3_next = Q30_ONE + qmul(sq2_reg, ts2_reg);
        c3_next  = Q30_ONE + qmul(sq2_reg, tc2_reg);
        s4       = qmul(x3_reg, ts3_reg);
        sin_next = sgn3_reg[1] ? 32'(-s4) : 32'(s4);
        cos_next = sgn3_reg[0] ? 32'(-c3_reg) : 32'(c3_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x0_reg   <= x_in;
            sq0_reg  <= sq0_next;
            sgn0_reg <= {in_data.sin_neg, in_data.cos_neg};
        end
        if (en[1]) begin
            x1_reg   <= x0_reg;
            sq1_reg  <= sq0_reg;
            ts1_reg  <= ts1_next;
            tc1_reg  <= tc1_next;
            sgn1_reg <= sgn0_reg;
        end
        if (en[2]) begin
            x2s_reg  <= x1_reg;
            sq2_reg  <= sq1_reg;
            ts2_reg  <= ts2_next;
            tc2_reg  <= tc2_next;
            sgn2_reg <= sgn1_reg;
        end
        if (en[3]) begin
            x3_reg   <= x2s_reg;
            ts3_reg  <= ts3_next;
            c3_reg   <= c3_next;
            sgn3_reg <= sgn2_reg;
        end
        if (en[4]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign sin_value = sin_reg;
    assign cos_value = cos_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sine_cosine_poly_unit_core.sv
// Sine/cosine unit: takes a Q8.24 angle in radians on one beat and returns
// sine and cosine in Q2.30 together on one result beat, through an
// eight-stage pipeline (three index stages, five polynomial stages), one
// beat per cycle sustained while m_tready stays high. Each stage holds one
// beat and advances whenever its successor can, so a stalled output only
// fills the pipeline; s_tready drops once eight beats, the unaccepted result
// among them, fill it. Polynomial stages follow the Horner multiplier chain.
// Depends on scp_pkg, scp_angle_index, scp_poly and the assertion macros.
`default_nettype none
`include "sine_cosine_poly_unit_core_defines.svh"

module sine_cosine_poly_unit_core #(
    parameter int unsigned ANGLE_INDEX_BITS = scp_pkg::ANGLE_INDEX_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] angle
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [31:0] sin_value, [63:32] cos_value
);
    import scp_pkg::*;

    logic               ang_valid;
    logic               ang_ready;
    scp_angle_t         ang_data;
    logic signed [31:0] sin_value;
    logic signed [31:0] cos_value;

    // Angle scaling, wrap and quarter-wave fold.
    scp_angle_index #(
        .B(ANGLE_INDEX_BITS)
    ) u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  (s_tdata),
        .out_valid (ang_valid),
        .out_ready (ang_ready),
        .out_data  (ang_data)
    );

    // Polynomial evaluation and sign application.
    scp_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_data   (ang_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sin_value (sin_value),
        .cos_value (cos_value)
    );

    assign m_tdata = {cos_value, sin_value};

    // The input side can only be blocked by a held result.
    `SCP_ASSERT_IMPLIES(a_stall_source, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
    // The folded angle never exceeds pi/2.
    `SCP_ASSERT_IMPLIES(a_fold_range, ang_valid, ang_data.x <= X_MAX, "folded angle above pi/2")
    // A beat held between the two halves keeps its angle.
    `SCP_ASSERT_NEXT(a_mid_hold, ang_valid && !ang_ready, ang_valid && $stable(ang_data), "held mid beat changed")

endmodule

`default_nettype wire

// File: sim/tb_sine_cosine_poly_unit_core.sv
// Self-checking testbench for sine_cosine_poly_unit_core: drives Q8.24 angles,
// predicts Q2.30 sine and cosine beats and compares them in order.
// Depends on the RTL of the unit and scp_pkg; reads no files.
module tb_sine_cosine_poly_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Angle index width and the fixed-point constants of the polynomial unit.
    localparam int unsigned         IDX_BITS    = 20;
    localparam longint unsigned     QUARTER     = 64'd1 << (IDX_BITS - 2);
    localparam longint unsigned     ANG_TO_IDX  = 64'd683565276;
    localparam longint unsigned     IDX_TO_RAD  = 64'd26986075409;
    localparam longint              ONE_Q30     = 64'sd1073741824;
    localparam longint              SIN_K2      = -64'sd178956971;
    localparam longint              SIN_K4      = 64'sd8947849;
    localparam longint              SIN_K6      = -64'sd205904;
    localparam longint              COS_K2      = -64'sd536870912;
    localparam longint              COS_K4      = 64'sd44739243;
    localparam longint              COS_K6      = -64'sd1427368;
    localparam int                  CYCLE_LIMIT = 200000;
    localparam int                  DRAIN_WAIT  = 24;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] sin_v;
        logic [31:0] cos_v;
    } sin_cos_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] angle
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] sin_value, [63:32] cos_value

    sin_cos_t pending_sin_cos[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       burst_left     = 0;

    sine_cosine_poly_unit_core #(
        .ANGLE_INDEX_BITS(IDX_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Free-running clock.
    always #5 aclk = ~aclk;

    // Q2.30 product, rounded to nearest with ties away from zero.
    function automatic longint round_q30_mul(input longint a, input longint b);
        longint unsigned mag_a;
        longint unsigned mag_b;
        longint unsigned prod;
        mag_a = (a < 0) ? longint'(-a) : a;
        mag_b = (b < 0) ? longint'(-b) : b;
        prod  = (mag_a * mag_b + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    // Expected sine and cosine of one angle.
    function automatic sin_cos_t predict_sin_cos(input logic [31:0] angle);
        sin_cos_t          res;
        longint unsigned   mag;
        longint unsigned   scaled;
        longint unsigned   wrapped;
        logic [IDX_BITS-1:0] idx;
        longint unsigned   folded;
        longint            x;
        longint            x2;
        longint            acc;
        longint            sin_q;
        longint            cos_q;
        mag     = angle[31] ? (64'h1_0000_0000 - angle) : {32'd0, angle};
        scaled  = (mag * ANG_TO_IDX) >> (56 - IDX_BITS);
        wrapped = angle[31] ? (64'd0 - scaled) : scaled;
        idx     = wrapped[IDX_BITS-1:0];
        folded  = 64'(idx[IDX_BITS-3:0]);
        // Second and fourth quarters run the angle backward from the boundary.
        if (idx[IDX_BITS-2])
            folded = QUARTER - folded;
        x  = longint'((folded * IDX_TO_RAD + (64'd1 << (IDX_BITS + 1))) >> (IDX_BITS + 2));
        x2 = round_q30_mul(x, x);

        acc   = SIN_K4 + round_q30_mul(x2, SIN_K6);
        acc   = SIN_K2 + round_q30_mul(x2, acc);
        acc   = ONE_Q30 + round_q30_mul(x2, acc);
        sin_q = round_q30_mul(x, acc);

        acc   = COS_K4 + round_q30_mul(x2, COS_K6);
        acc   = COS_K2 + round_q30_mul(x2, acc);
        cos_q = ONE_Q30 + round_q30_mul(x2, acc);

        if (idx[IDX_BITS-1])
            sin_q = -sin_q;
        if (idx[IDX_BITS-1] != idx[IDX_BITS-2])
            cos_q = -cos_q;
        res.angle = angle;
        res.sin_v = sin_q[31:0];
        res.cos_v = cos_q[31:0];
        return res;
    endfunction

    // Smallest positive angle whose binary index reaches k.
    function automatic logic [31:0] angle_at_index(input longint unsigned k);
        longint unsigned mag;
        mag = ((k << (56 - IDX_BITS)) + ANG_TO_IDX - 1) / ANG_TO_IDX;
        return mag[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] angle,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s angle=%h got=%h want=%h", what, angle, got, want);
        mismatch_count++;
    endtask

    // Send one angle beat; bursts of random length with random gaps between them.
    task automatic send_angle(input logic [31:0] angle);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        do @(posedge aclk); while (!s_tready);
        pending_sin_cos.push_back(predict_sin_cos(angle));
    endtask

    // Receiver stalls on a rotating mask that changes its character now and then.
    logic [15:0] ready_mask = 16'hFFFF;
    int          ready_phase = 0;
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(0, 3))
                0: ready_mask = 16'hFFFF;
                1: ready_mask = 16'($urandom()) | 16'h0001;
                2: ready_mask = 16'($urandom() & $urandom()) | 16'h0001;
                default: ready_mask = 16'($urandom()) | 16'h8001;
            endcase
            ready_phase = $urandom_range(40, 160);
        end else begin
            ready_phase--;
            ready_mask = {ready_mask[14:0], ready_mask[15]};
        end
        m_tready <= ready_mask[0];
    end

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge aclk) begin
        sin_cos_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sin_cos.size() == 0) begin
                report_mismatch("unexpected beat", 32'd0, m_tdata[31:0], 32'd0);
            end else begin
                want = pending_sin_cos.pop_front();
                if (m_tdata[31:0] !== want.sin_v)
                    report_mismatch("sin_value", want.angle, m_tdata[31:0], want.sin_v);
                if (m_tdata[63:32] !== want.cos_v)
                    report_mismatch("cos_value", want.angle, m_tdata[63:32], want.cos_v);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Extremes of the angle field and alternating bit patterns.
    task automatic test_field_extremes();
        send_angle(32'h0000_0000);
        send_angle(32'h0000_0001);
        send_angle(32'hFFFF_FFFF);
        send_angle(32'h7FFF_FFFF);
        send_angle(32'h8000_0000);
        send_angle(32'h8000_0001);
        send_angle(32'h5555_5555);
        send_angle(32'hAAAA_AAAA);
        send_angle(32'd26353589);       // pi/2 in Q8.24
        send_angle(-32'sd26353589);
    endtask

    // Quarter boundaries, where the fold gives exactly pi/2 or zero, and the wrap at 2*pi.
    task automatic test_quarter_boundaries();
        logic [31:0] a;
        for (int q = 1; q <= 4; q++) begin
            a = angle_at_index(QUARTER * q);
            send_angle(a);
            send_angle(-a);
            send_angle(a - 32'd1);
        end
        a = angle_at_index((64'd1 << IDX_BITS) - 1);
        send_angle(a);
        send_angle(-a);
    endtask

    // Angles within a few turns, where folding and signs matter most.
    task automatic test_random_small_angles(input int count);
        logic [31:0] a;
        repeat (count) begin
            a = $urandom_range(0, 32'h1000_0000);
            send_angle($urandom_range(0, 1) ? -a : a);
        end
    endtask

    // Any 32-bit pattern; large angles wrap.
    task automatic test_random_full_range(input int count);
        repeat (count) send_angle($urandom());
    endtask

    // Angles a few index steps around quarter boundaries, including wrapped turns.
    task automatic test_random_near_boundaries(input int count);
        logic [31:0] a;
        longint unsigned k;
        repeat (count) begin
            k = QUARTER * $urandom_range(0, 64) + $urandom_range(0, 6);
            a = angle_at_index(k) - $urandom_range(0, 300);
            send_angle($urandom_range(0, 1) ? -a : a);
        end
    endtask

    // Reset, run the tests in turn, drain and report.
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_quarter_boundaries();
        test_random_small_angles(480);
        test_random_full_range(400);
        test_random_near_boundaries(350);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_sin_cos.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
